// ===== src/hmtt_pkg.sv =====
package hmtt_pkg;

   localparam int MAX_GRID_DEF = 1024;

   localparam int SAMPLE_W = 16;
   localparam int HEIGHT_W = 16;
   localparam int COORD_W = 26;
   localparam int GRID_W = 11;
   localparam int SCALE_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 2;

   localparam int VERTEX_W = 2 * COORD_W + HEIGHT_W;
   localparam int PAYLOAD_W = 3 * VERTEX_W;
   localparam int RSP_DATA_W = ((PAYLOAD_W + 7) / 8) * 8;
   localparam int REQ_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

   localparam logic [GRID_W-1:0] GRID_SIZE_RST = GRID_W'(1024);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX_RST = HEIGHT_W'(256);
   localparam logic [SCALE_W-1:0] XY_SCALE_RST = SCALE_W'(256);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRID_SIZE  = 2'd0,
      CSR_HEIGHT_MAX = 2'd1,
      CSR_XY_SCALE   = 2'd2
   } csr_index_type;

endpackage

// ===== src/hmtt_ram.sv =====
module hmtt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/heightmap_triangle_tessellator.sv =====
// Channel | Direction | Handshake            | Contents
// req     | in        | tvalid/tready        | tdata[15:0] height_sample
// rsp     | out       | tvalid/tready/tlast  | tdata: v0_x v0_h v0_z v1_x v1_h v1_z
//         |           |                      |        v2_x v2_h v2_z, tlast last_of_cell
// csr     | in        | csr_we               | csr_addr register index, csr_wdata value
//
// A sample in row 0 or column 0 emits nothing; any other sample emits two triangle beats
// from the two-beat result register, and the next cell loads as its second beat is taken.
// First triangle beat shows after its sample passes the line store read into the read
// stage, then the coordinate multiply into the result register.
// Reset clears counters, neighbor heights and valids; the line store is not cleared.
// A stalled rsp side holds one sample in the read stage, then backpressures req.
module heightmap_triangle_tessellator
   import hmtt_pkg::*;
#(
   parameter int MAX_GRID = MAX_GRID_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] height_sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [25:0] v0_x, [41:26] v0_h, [67:42] v0_z, [93:68] v1_x, [109:94] v1_h,
   // [135:110] v1_z, [161:136] v2_x, [177:162] v2_h, [203:178] v2_z, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // last_of_cell
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_GRID);
   localparam int GW = CW + 1;
   localparam int EW = (GW > GRID_W) ? GW : GRID_W;
   localparam int PW = CW + SCALE_W;

   logic [GRID_W-1:0]   grid_size_ff;
   logic [HEIGHT_W-1:0] height_max_ff;
   logic [SCALE_W-1:0]  xy_scale_ff;

   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [CW-1:0] row_cnt_ff, row_cnt_in;

   logic                s1_v_ff;
   logic                s1_emit_ff;
   logic [CW-1:0]       s1_col_ff, s1_row_ff;
   logic [HEIGHT_W-1:0] s1_cur_ff;

   logic [HEIGHT_W-1:0] left_ff, ul_ff;

   logic                out_v_ff, phase_ff;
   logic [COORD_W-1:0]  xa_ff, xb_ff, za_ff, zb_ff;
   logic [HEIGHT_W-1:0] o_left_ff, o_ul_ff, o_above_ff, o_cur_ff;

   logic [EW-1:0]       grid_ext;
   logic [GW-1:0]       g_eff;
   logic                col_wrap;
   logic [GW-1:0]       row_pre, col_nxt, row_nxt;
   logic [CW-1:0]       col_cur, row_cur;
   logic [2*SAMPLE_W-1:0] scale_prod;
   logic [HEIGHT_W-1:0] cur_h;
   logic [HEIGHT_W-1:0] above_h;
   logic                accept, out_free, s1_fire;
   logic [PW-1:0]       x_prod, z_prod;
   logic [COORD_W-1:0]  x_hi, z_hi;
   logic [COORD_W-1:0]  v0_x, v0_z, v1_x, v1_z, v2_x, v2_z;
   logic [HEIGHT_W-1:0] v0_h, v1_h, v2_h;

   // effective grid size, counter position of the incoming sample and next counter values
   always_comb begin
      grid_ext = EW'(grid_size_ff);
      if (grid_ext < EW'(2)) begin
         g_eff = GW'(2);
      end else if (grid_ext > EW'(MAX_GRID)) begin
         g_eff = GW'(MAX_GRID);
      end else begin
         g_eff = GW'(grid_ext);
      end

      col_wrap = {1'b0, col_cnt_ff} >= g_eff;
      col_cur  = col_wrap ? '0 : col_cnt_ff;
      row_pre  = col_wrap ? ({1'b0, row_cnt_ff} + GW'(1)) : {1'b0, row_cnt_ff};
      row_cur  = (row_pre >= g_eff) ? '0 : row_pre[CW-1:0];

      col_nxt = {1'b0, col_cur} + GW'(1);
      row_nxt = {1'b0, row_cur} + GW'(1);
      if (col_nxt >= g_eff) begin
         col_cnt_in = '0;
         row_cnt_in = (row_nxt >= g_eff) ? '0 : row_nxt[CW-1:0];
      end else begin
         col_cnt_in = col_nxt[CW-1:0];
         row_cnt_in = row_cur;
      end
   end

   assign scale_prod = height_max_ff * req_tdata[SAMPLE_W-1:0];
   assign cur_h      = scale_prod[2*SAMPLE_W-1:SAMPLE_W];

   assign out_free   = !out_v_ff || (rsp_tready && phase_ff);
   assign s1_fire    = s1_v_ff && (!s1_emit_ff || out_free);
   assign req_tready = !s1_v_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   hmtt_ram #(
      .WIDTH(HEIGHT_W),
      .DEPTH(MAX_GRID)
   ) u_line_store (
      .clock(clock),
      .we   (accept),
      .waddr(col_cur),
      .wdata(cur_h),
      .re   (accept),
      .raddr(col_cur),
      .rdata(above_h)
   );

   assign x_prod = s1_col_ff * xy_scale_ff;
   assign z_prod = s1_row_ff * xy_scale_ff;
   assign x_hi   = COORD_W'(x_prod);
   assign z_hi   = COORD_W'(z_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff  <= GRID_SIZE_RST;
         height_max_ff <= HEIGHT_MAX_RST;
         xy_scale_ff   <= XY_SCALE_RST;
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         s1_v_ff       <= 1'b0;
         left_ff       <= '0;
         ul_ff         <= '0;
         out_v_ff      <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_GRID_SIZE:  grid_size_ff  <= csr_wdata[GRID_W-1:0];
               CSR_HEIGHT_MAX: height_max_ff <= csr_wdata[HEIGHT_W-1:0];
               CSR_XY_SCALE:   xy_scale_ff   <= csr_wdata[SCALE_W-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
            s1_v_ff    <= 1'b1;
         end else if (s1_fire) begin
            s1_v_ff <= 1'b0;
         end

         if (s1_fire) begin
            left_ff <= s1_cur_ff;
            ul_ff   <= above_h;
         end

         if (s1_fire && s1_emit_ff) begin
            out_v_ff <= 1'b1;
            phase_ff <= 1'b0;
         end else if (out_v_ff && rsp_tready) begin
            out_v_ff <= !phase_ff;
            phase_ff <= !phase_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_cur;
         s1_row_ff  <= row_cur;
         s1_cur_ff  <= cur_h;
         s1_emit_ff <= (col_cur != '0) && (row_cur != '0);
      end
      if (s1_fire && s1_emit_ff) begin
         xa_ff      <= x_hi;
         xb_ff      <= x_hi - COORD_W'(xy_scale_ff);
         za_ff      <= z_hi;
         zb_ff      <= z_hi - COORD_W'(xy_scale_ff);
         o_left_ff  <= left_ff;
         o_ul_ff    <= ul_ff;
         o_above_ff <= above_h;
         o_cur_ff   <= s1_cur_ff;
      end
   end

   always_comb begin
      v1_x = xa_ff;
      v1_h = o_above_ff;
      v1_z = zb_ff;
      v2_x = xb_ff;
      if (phase_ff) begin
         v0_x = xa_ff;
         v0_h = o_cur_ff;
         v0_z = za_ff;
         v2_h = o_left_ff;
         v2_z = za_ff;
      end else begin
         v0_x = xb_ff;
         v0_h = o_left_ff;
         v0_z = za_ff;
         v2_h = o_ul_ff;
         v2_z = zb_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = phase_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PAYLOAD_W)'(0),
                        v2_z, v2_h, v2_x, v1_z, v1_h, v1_x, v0_z, v0_h, v0_x};

   a_phase_needs_valid: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> out_v_ff)
      else $error("second triangle phase without a held result");

   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("first triangle not followed by second");

   a_emit_loads_first: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_emit_ff) |=> (out_v_ff && !phase_ff))
      else $error("cell not loaded into result register");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast && !(s1_fire && s1_emit_ff)) |=> !out_v_ff)
      else $error("result register holds a stale cell");

endmodule
